// ===== rtl/core/ttc_pkg.sv =====
// ---------------------------------------------------------------------------
// Triangle tile coverage package
// Shared types, constants and register indexes for the tile rasterizer.
// ---------------------------------------------------------------------------
package ttc_pkg;

    localparam int TILE_SIDE_DEF = 8;
    localparam int MAX_FRAME_DEF = 2048;
    localparam int FRAC_BITS_DEF = 4;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_RED     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_GREEN   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_BLUE    = 3'd4;

    localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;
    localparam logic [7:0]  BASE_RED_RST     = 8'd168;
    localparam logic [7:0]  BASE_GREEN_RST   = 8'd198;
    localparam logic [7:0]  BASE_BLUE_RST    = 8'd255;

    // Edge function operands: doubled 16-bit coordinates fit in 18 bits.
    localparam int CW = 19;
    localparam int PW = 2 * CW + 1;

    typedef struct packed {
        logic signed [15:0] vert_a_x;
        logic signed [15:0] vert_a_y;
        logic signed [15:0] vert_b_x;
        logic signed [15:0] vert_b_y;
        logic signed [15:0] vert_c_x;
        logic signed [15:0] vert_c_y;
        logic [8:0]         shade_level;
        logic [7:0]         tile_col;
        logic [7:0]         tile_row;
    } tri_item_t;

    typedef struct packed {
        logic [63:0] coverage_mask;
        logic [7:0]  pixel_red;
        logic [7:0]  pixel_green;
        logic [7:0]  pixel_blue;
    } tile_result_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    function automatic logic [7:0] shade_chan(input logic [7:0] base, input logic [8:0] shade);
        logic [16:0] prod;
        prod = base * shade;
        shade_chan = (prod[16:8] > 9'd255) ? 8'd255 : prod[15:8];
    endfunction

endpackage

// ===== rtl/core/ttc_setup.sv =====
// ---------------------------------------------------------------------------
// Triangle setup stage
// Registers doubled vertices, edge deltas, the clipped box and the shade.
// ---------------------------------------------------------------------------
module ttc_setup #(
    parameter int MAX_FRAME = ttc_pkg::MAX_FRAME_DEF,
    parameter int FRAC_BITS = ttc_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  ttc_pkg::tri_item_t         item,
    input  logic [11:0]                frame_width,
    input  logic [11:0]                frame_height,
    input  ttc_pkg::rgb_t              base_rgb,
    output logic                       out_valid,
    output logic signed [ttc_pkg::CW-1:0] vx_out [3],
    output logic signed [ttc_pkg::CW-1:0] vy_out [3],
    output logic signed [ttc_pkg::CW-1:0] dx_out [3],
    output logic signed [ttc_pkg::CW-1:0] dy_out [3],
    output logic signed [13:0]         min_x,
    output logic signed [13:0]         max_x,
    output logic signed [13:0]         min_y,
    output logic signed [13:0]         max_y,
    output logic [7:0]                 tile_col,
    output logic [7:0]                 tile_row,
    output ttc_pkg::rgb_t              rgb
);

    localparam logic [12:0] MAXF = 13'(MAX_FRAME);

    logic signed [15:0] xs [3];
    logic signed [15:0] ys [3];
    logic signed [15:0] mnx, mxx, mny, mxy;
    logic signed [16:0] lo_x, hi_x, lo_y, hi_y;
    logic [12:0] w_eff, h_eff;
    logic valid_reg;

    function automatic logic signed [15:0] min3(input logic signed [15:0] a,
        input logic signed [15:0] b, input logic signed [15:0] c);
        logic signed [15:0] m;
        m = (a < b) ? a : b;
        min3 = (m < c) ? m : c;
    endfunction

    function automatic logic signed [15:0] max3(input logic signed [15:0] a,
        input logic signed [15:0] b, input logic signed [15:0] c);
        logic signed [15:0] m;
        m = (a > b) ? a : b;
        max3 = (m > c) ? m : c;
    endfunction

    always_comb
    begin
        xs[0] = item.vert_a_x; xs[1] = item.vert_b_x; xs[2] = item.vert_c_x;
        ys[0] = item.vert_a_y; ys[1] = item.vert_b_y; ys[2] = item.vert_c_y;
        mnx = min3(xs[0], xs[1], xs[2]);
        mxx = max3(xs[0], xs[1], xs[2]);
        mny = min3(ys[0], ys[1], ys[2]);
        mxy = max3(ys[0], ys[1], ys[2]);
        // Arithmetic shift floors; ceiling is the floor of value plus one less than a pixel.
        lo_x = 17'(mnx) >>> FRAC_BITS;
        lo_y = 17'(mny) >>> FRAC_BITS;
        hi_x = (17'(mxx) + 17'((1 << FRAC_BITS) - 1)) >>> FRAC_BITS;
        hi_y = (17'(mxy) + 17'((1 << FRAC_BITS) - 1)) >>> FRAC_BITS;
        w_eff = ({1'b0, frame_width} > MAXF) ? MAXF : {1'b0, frame_width};
        h_eff = ({1'b0, frame_height} > MAXF) ? MAXF : {1'b0, frame_height};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            vx_out[i] <= ttc_pkg::CW'(xs[i]) <<< 1;
            vy_out[i] <= ttc_pkg::CW'(ys[i]) <<< 1;
            dx_out[i] <= (ttc_pkg::CW'(xs[(i + 1) % 3]) - ttc_pkg::CW'(xs[i])) <<< 1;
            dy_out[i] <= (ttc_pkg::CW'(ys[(i + 1) % 3]) - ttc_pkg::CW'(ys[i])) <<< 1;
        end
        min_x <= (lo_x < 0) ? 14'sd0 : 14'(lo_x);
        min_y <= (lo_y < 0) ? 14'sd0 : 14'(lo_y);
        max_x <= (hi_x > 17'($signed({1'b0, w_eff})) - 17'sd1) ?
                 14'($signed({1'b0, w_eff})) - 14'sd1 : 14'(hi_x);
        max_y <= (hi_y > 17'($signed({1'b0, h_eff})) - 17'sd1) ?
                 14'($signed({1'b0, h_eff})) - 14'sd1 : 14'(hi_y);
        tile_col <= item.tile_col;
        tile_row <= item.tile_row;
        rgb.red   <= ttc_pkg::shade_chan(base_rgb.red, item.shade_level);
        rgb.green <= ttc_pkg::shade_chan(base_rgb.green, item.shade_level);
        rgb.blue  <= ttc_pkg::shade_chan(base_rgb.blue, item.shade_level);
    end

    assign out_valid = valid_reg;

endmodule

// ===== rtl/core/ttc_edge.sv =====
// ---------------------------------------------------------------------------
// Edge evaluation stages
// Forms each edge at the tile origin with two multipliers, then steps it
// across the tile by adding multiples of the deltas and tests each pixel.
// ---------------------------------------------------------------------------
module ttc_edge #(
    parameter int TILE_SIDE = ttc_pkg::TILE_SIDE_DEF,
    parameter int FRAC_BITS = ttc_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [ttc_pkg::CW-1:0] vx [3],
    input  logic signed [ttc_pkg::CW-1:0] vy [3],
    input  logic signed [ttc_pkg::CW-1:0] dx [3],
    input  logic signed [ttc_pkg::CW-1:0] dy [3],
    input  logic signed [13:0]            min_x,
    input  logic signed [13:0]            max_x,
    input  logic signed [13:0]            min_y,
    input  logic signed [13:0]            max_y,
    input  logic [7:0]                    tile_col,
    input  logic [7:0]                    tile_row,
    input  ttc_pkg::rgb_t                 rgb_in,
    output logic                          out_valid,
    output logic [63:0]                   mask,
    output ttc_pkg::rgb_t                 rgb_out
);

    localparam int CW = ttc_pkg::CW;
    localparam int PW = ttc_pkg::PW;
    localparam int STEP = 2 << FRAC_BITS;

    // Stage A: origin pixel centre offsets.
    logic signed [CW-1:0] ox_a_reg [3];
    logic signed [CW-1:0] oy_a_reg [3];
    logic signed [CW-1:0] dx_a_reg [3];
    logic signed [CW-1:0] dy_a_reg [3];
    logic signed [13:0]   x0_a_reg, y0_a_reg;
    logic signed [13:0]   mnx_a_reg, mxx_a_reg, mny_a_reg, mxy_a_reg;
    ttc_pkg::rgb_t        rgb_a_reg;
    logic                 valid_a_reg;

    // Stage B: products.
    logic signed [PW-1:0] p0_b_reg [3];
    logic signed [PW-1:0] p1_b_reg [3];
    logic signed [CW-1:0] dx_b_reg [3];
    logic signed [CW-1:0] dy_b_reg [3];
    logic [TILE_SIDE-1:0] colok_b_reg, rowok_b_reg;
    ttc_pkg::rgb_t        rgb_b_reg;
    logic                 valid_b_reg;

    // Stage C: origin edge values.
    logic signed [PW:0]   e_c_reg [3];
    logic signed [CW-1:0] dx_c_reg [3];
    logic signed [CW-1:0] dy_c_reg [3];
    logic [TILE_SIDE-1:0] colok_c_reg, rowok_c_reg;
    ttc_pkg::rgb_t        rgb_c_reg;
    logic                 valid_c_reg;

    // Stage D: mask.
    logic [63:0]          mask_reg;
    ttc_pkg::rgb_t        rgb_d_reg;
    logic                 valid_d_reg;

    logic signed [13:0] x0, y0;
    logic [63:0] mask_next;

    always_comb
    begin
        x0 = $signed({6'd0, tile_col}) * 14'(TILE_SIDE);
        y0 = $signed({6'd0, tile_row}) * 14'(TILE_SIDE);
    end

    always_comb
    begin
        logic signed [PW+4:0] e [3];
        logic ge, le;
        mask_next = '0;
        for (int r = 0; r < TILE_SIDE; r++)
        begin
            for (int c = 0; c < TILE_SIDE; c++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    e[k] = (PW+5)'(e_c_reg[k])
                         + (PW+5)'(dy_c_reg[k]) * (PW+5)'(c * STEP)
                         - (PW+5)'(dx_c_reg[k]) * (PW+5)'(r * STEP);
                end
                ge = (e[0] >= 0) && (e[1] >= 0) && (e[2] >= 0);
                le = (e[0] <= 0) && (e[1] <= 0) && (e[2] <= 0);
                mask_next[r * TILE_SIDE + c] = (ge || le) && colok_c_reg[c] && rowok_c_reg[r];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
            valid_d_reg <= valid_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            ox_a_reg[k] <= CW'(x0) * CW'(STEP) + CW'(1 << FRAC_BITS) - vx[k];
            oy_a_reg[k] <= CW'(y0) * CW'(STEP) + CW'(1 << FRAC_BITS) - vy[k];
            dx_a_reg[k] <= dx[k];
            dy_a_reg[k] <= dy[k];
        end
        x0_a_reg  <= x0;
        y0_a_reg  <= y0;
        mnx_a_reg <= min_x;
        mxx_a_reg <= max_x;
        mny_a_reg <= min_y;
        mxy_a_reg <= max_y;
        rgb_a_reg <= rgb_in;

        for (int k = 0; k < 3; k++)
        begin
            p0_b_reg[k] <= PW'(ox_a_reg[k]) * PW'(dy_a_reg[k]);
            p1_b_reg[k] <= PW'(oy_a_reg[k]) * PW'(dx_a_reg[k]);
            dx_b_reg[k] <= dx_a_reg[k];
            dy_b_reg[k] <= dy_a_reg[k];
        end
        for (int i = 0; i < TILE_SIDE; i++)
        begin
            colok_b_reg[i] <= (x0_a_reg + 14'(i) >= mnx_a_reg) && (x0_a_reg + 14'(i) <= mxx_a_reg);
            rowok_b_reg[i] <= (y0_a_reg + 14'(i) >= mny_a_reg) && (y0_a_reg + 14'(i) <= mxy_a_reg);
        end
        rgb_b_reg <= rgb_a_reg;

        for (int k = 0; k < 3; k++)
        begin
            e_c_reg[k]  <= (PW+1)'(p0_b_reg[k]) - (PW+1)'(p1_b_reg[k]);
            dx_c_reg[k] <= dx_b_reg[k];
            dy_c_reg[k] <= dy_b_reg[k];
        end
        colok_c_reg <= colok_b_reg;
        rowok_c_reg <= rowok_b_reg;
        rgb_c_reg   <= rgb_b_reg;

        mask_reg  <= mask_next;
        rgb_d_reg <= rgb_c_reg;
    end

    assign out_valid = valid_d_reg;
    assign mask      = mask_reg;
    assign rgb_out   = rgb_d_reg;

endmodule

// ===== rtl/core/triangle_tile_coverage_unit.sv =====
// ---------------------------------------------------------------------------
// Triangle tile coverage unit
// Edge-function rasterizer producing an 8x8 tile coverage mask and a shaded color.
// ---------------------------------------------------------------------------
// An item can be accepted in every clock cycle; busy is never raised. Each result
// is on done for one cycle. Between the accepting edge and done lie these register
// stages: the setup register, the edge stages (origin offsets, multipliers, edge
// sum) and the mask register. The receiver cannot stall the unit.
module triangle_tile_coverage_unit #(
    parameter int TILE_SIDE = ttc_pkg::TILE_SIDE_DEF,
    parameter int MAX_FRAME = ttc_pkg::MAX_FRAME_DEF,
    parameter int FRAC_BITS = ttc_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  ttc_pkg::tri_item_t                item,
    output logic                              done,
    output ttc_pkg::tile_result_t             result,
    input  logic                              cfg_we,
    input  logic [ttc_pkg::CFG_ADDR_W-1:0]    cfg_index,
    input  logic [ttc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [11:0] frame_width_reg, frame_height_reg;
    ttc_pkg::rgb_t base_reg;

    logic s_valid;
    logic signed [ttc_pkg::CW-1:0] vx [3];
    logic signed [ttc_pkg::CW-1:0] vy [3];
    logic signed [ttc_pkg::CW-1:0] dx [3];
    logic signed [ttc_pkg::CW-1:0] dy [3];
    logic signed [13:0] min_x, max_x, min_y, max_y;
    logic [7:0] tcol, trow;
    ttc_pkg::rgb_t s_rgb, e_rgb;
    logic [63:0] mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= ttc_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= ttc_pkg::FRAME_HEIGHT_RST;
            base_reg.red     <= ttc_pkg::BASE_RED_RST;
            base_reg.green   <= ttc_pkg::BASE_GREEN_RST;
            base_reg.blue    <= ttc_pkg::BASE_BLUE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ttc_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                ttc_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                ttc_pkg::REG_BASE_RED:     base_reg.red     <= cfg_data[7:0];
                ttc_pkg::REG_BASE_GREEN:   base_reg.green   <= cfg_data[7:0];
                ttc_pkg::REG_BASE_BLUE:    base_reg.blue    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    ttc_setup #(
        .MAX_FRAME(MAX_FRAME),
        .FRAC_BITS(FRAC_BITS)
    ) u_setup (
        .clk(clk), .rst_n(rst_n), .in_valid(start), .item(item),
        .frame_width(frame_width_reg), .frame_height(frame_height_reg),
        .base_rgb(base_reg), .out_valid(s_valid),
        .vx_out(vx), .vy_out(vy), .dx_out(dx), .dy_out(dy),
        .min_x(min_x), .max_x(max_x), .min_y(min_y), .max_y(max_y),
        .tile_col(tcol), .tile_row(trow), .rgb(s_rgb)
    );

    ttc_edge #(
        .TILE_SIDE(TILE_SIDE),
        .FRAC_BITS(FRAC_BITS)
    ) u_edge (
        .clk(clk), .rst_n(rst_n), .in_valid(s_valid),
        .vx(vx), .vy(vy), .dx(dx), .dy(dy),
        .min_x(min_x), .max_x(max_x), .min_y(min_y), .max_y(max_y),
        .tile_col(tcol), .tile_row(trow), .rgb_in(s_rgb),
        .out_valid(done), .mask(mask), .rgb_out(e_rgb)
    );

    assign result.coverage_mask = mask;
    assign result.pixel_red     = e_rgb.red;
    assign result.pixel_green   = e_rgb.green;
    assign result.pixel_blue    = e_rgb.blue;

endmodule

// ===== test/triangle_tile_coverage_unit_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Triangle tile coverage unit test
// Drives triangles and tile positions through the rasterizer, with random
// gaps between items. A local edge-function predictor computes the expected
// coverage mask and shaded color for each item. Runs under several frame
// and color settings.
// ---------------------------------------------------------------------------
module triangle_tile_coverage_unit_test;

    localparam int LIMIT = 400000;
    localparam int TAIL = 20;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    ttc_pkg::tri_item_t item;
    logic done;
    ttc_pkg::tile_result_t result;
    logic cfg_we;
    logic [ttc_pkg::CFG_ADDR_W-1:0] cfg_index;
    logic [ttc_pkg::CFG_DATA_W-1:0] cfg_data;

    ttc_pkg::tri_item_t pending_tris[$];
    ttc_pkg::tile_result_t expected_tiles[$];
    int gap_left;
    int cycles;
    int failures;
    int tiles_checked;
    int covered_tiles;
    logic feeding;

    logic [11:0] frame_w;
    logic [11:0] frame_h;
    logic [7:0] red_base;
    logic [7:0] green_base;
    logic [7:0] blue_base;

    triangle_tile_coverage_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint floor_pixel(longint v);
        if (v >= 0)
        begin
            return v >>> 4;
        end
        return -((-v + 15) >>> 4);
    endfunction

    function automatic logic [7:0] scale_channel(logic [7:0] base, logic [8:0] shade);
        longint prod;
        prod = (longint'(base) * longint'(shade)) >>> 8;
        return (prod > 255) ? 8'd255 : prod[7:0];
    endfunction

    function automatic ttc_pkg::tile_result_t rasterize_tile(ttc_pkg::tri_item_t t);
        ttc_pkg::tile_result_t res;
        longint ax, ay, bx, by, cx, cy, w, h;
        longint minx, maxx, miny, maxy, x, y, px, py, e0, e1, e2;
        ax = t.vert_a_x; ay = t.vert_a_y;
        bx = t.vert_b_x; by = t.vert_b_y;
        cx = t.vert_c_x; cy = t.vert_c_y;
        w = (frame_w > 2048) ? 2048 : frame_w;
        h = (frame_h > 2048) ? 2048 : frame_h;
        minx = floor_pixel((ax < bx) ? ((ax < cx) ? ax : cx) : ((bx < cx) ? bx : cx));
        miny = floor_pixel((ay < by) ? ((ay < cy) ? ay : cy) : ((by < cy) ? by : cy));
        maxx = -floor_pixel(-((ax > bx) ? ((ax > cx) ? ax : cx) : ((bx > cx) ? bx : cx)));
        maxy = -floor_pixel(-((ay > by) ? ((ay > cy) ? ay : cy) : ((by > cy) ? by : cy)));
        if (minx < 0) minx = 0;
        if (miny < 0) miny = 0;
        if (maxx > w - 1) maxx = w - 1;
        if (maxy > h - 1) maxy = h - 1;
        ax *= 2; ay *= 2; bx *= 2; by *= 2; cx *= 2; cy *= 2;
        res.coverage_mask = '0;
        for (int r = 0; r < 8; r++)
        begin
            for (int c = 0; c < 8; c++)
            begin
                y = longint'(t.tile_row) * 8 + r;
                x = longint'(t.tile_col) * 8 + c;
                if (y >= miny && y <= maxy && x >= minx && x <= maxx)
                begin
                    px = x * 32 + 16;
                    py = y * 32 + 16;
                    e0 = (px - ax) * (by - ay) - (py - ay) * (bx - ax);
                    e1 = (px - bx) * (cy - by) - (py - by) * (cx - bx);
                    e2 = (px - cx) * (ay - cy) - (py - cy) * (ax - cx);
                    if ((e0 >= 0 && e1 >= 0 && e2 >= 0) || (e0 <= 0 && e1 <= 0 && e2 <= 0))
                        res.coverage_mask[r * 8 + c] = 1'b1;
                end
            end
        end
        res.pixel_red = scale_channel(red_base, t.shade_level);
        res.pixel_green = scale_channel(green_base, t.shade_level);
        res.pixel_blue = scale_channel(blue_base, t.shade_level);
        return res;
    endfunction

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_tiles.insert(expected_tiles.size(), rasterize_tile(item));
            end
            if (start && busy)
            begin
                start <= 1'b1;
            end
            else if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (feeding && pending_tris.size() > 0)
            begin
                item <= pending_tris.pop_front();
                start <= 1'b1;
                gap_left <= $urandom_range(0, 11);
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_tiles.size() == 0)
            begin
                $error("Result with no item outstanding: mask %h", result.coverage_mask);
                failures++;
            end
            else
            begin
                ttc_pkg::tile_result_t exp_tile;
                exp_tile = expected_tiles.pop_front();
                tiles_checked++;
                if (exp_tile.coverage_mask != 0)
                    covered_tiles++;
                if (result.coverage_mask !== exp_tile.coverage_mask)
                begin
                    $error("coverage_mask expected %h actual %h",
                        exp_tile.coverage_mask, result.coverage_mask);
                    failures++;
                end
                if (result.pixel_red !== exp_tile.pixel_red)
                begin
                    $error("pixel_red expected %0d actual %0d",
                        exp_tile.pixel_red, result.pixel_red);
                    failures++;
                end
                if (result.pixel_green !== exp_tile.pixel_green)
                begin
                    $error("pixel_green expected %0d actual %0d",
                        exp_tile.pixel_green, result.pixel_green);
                    failures++;
                end
                if (result.pixel_blue !== exp_tile.pixel_blue)
                begin
                    $error("pixel_blue expected %0d actual %0d",
                        exp_tile.pixel_blue, result.pixel_blue);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Timed out after %0d cycles.", cycles);
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_register(logic [ttc_pkg::CFG_ADDR_W-1:0] idx,
                                  logic [ttc_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            ttc_pkg::REG_FRAME_WIDTH: frame_w = val;
            ttc_pkg::REG_FRAME_HEIGHT: frame_h = val;
            ttc_pkg::REG_BASE_RED: red_base = val[7:0];
            ttc_pkg::REG_BASE_GREEN: green_base = val[7:0];
            ttc_pkg::REG_BASE_BLUE: blue_base = val[7:0];
            default: ;
        endcase
    endtask

    task automatic drain;
        while (pending_tris.size() > 0 || start || expected_tiles.size() > 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
    endtask

    task automatic enqueue_tri(ttc_pkg::tri_item_t t);
        pending_tris.insert(pending_tris.size(), t);
    endtask

    function automatic logic [15:0] near_coord(int centre);
        return 16'(centre * 16 + $signed($urandom_range(0, 1023)) - 512);
    endfunction

    task automatic queue_random(int count);
        ttc_pkg::tri_item_t t;
        int cx0, cy0;
        for (int n = 0; n < count; n++)
        begin
            t.tile_col = 8'($urandom_range(0, 255));
            t.tile_row = 8'($urandom_range(0, 255));
            t.shade_level = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(257, 511))
                : 9'($urandom_range(0, 256));
            if ($urandom_range(0, 4) == 0)
            begin
                t.vert_a_x = 16'($urandom); t.vert_a_y = 16'($urandom);
                t.vert_b_x = 16'($urandom); t.vert_b_y = 16'($urandom);
                t.vert_c_x = 16'($urandom); t.vert_c_y = 16'($urandom);
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    t.tile_col = 8'($urandom_range(0, 20));
                    t.tile_row = 8'($urandom_range(0, 20));
                end
                cx0 = t.tile_col * 8 + 4;
                cy0 = t.tile_row * 8 + 4;
                t.vert_a_x = near_coord(cx0); t.vert_a_y = near_coord(cy0);
                t.vert_b_x = near_coord(cx0); t.vert_b_y = near_coord(cy0);
                t.vert_c_x = near_coord(cx0); t.vert_c_y = near_coord(cy0);
                if ($urandom_range(0, 15) == 0)
                begin
                    t.vert_c_x = t.vert_b_x;
                    t.vert_c_y = t.vert_b_y;
                end
            end
            enqueue_tri(t);
        end
    endtask

    task automatic queue_tri(int ax, int ay, int bx, int by, int cx, int cy,
                             int shade, int col, int row);
        ttc_pkg::tri_item_t t;
        t.vert_a_x = 16'(ax); t.vert_a_y = 16'(ay);
        t.vert_b_x = 16'(bx); t.vert_b_y = 16'(by);
        t.vert_c_x = 16'(cx); t.vert_c_y = 16'(cy);
        t.shade_level = 9'(shade);
        t.tile_col = 8'(col);
        t.tile_row = 8'(row);
        enqueue_tri(t);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        feeding = 1'b0;
        cycles = 0;
        failures = 0;
        tiles_checked = 0;
        covered_tiles = 0;
        frame_w = ttc_pkg::FRAME_WIDTH_RST;
        frame_h = ttc_pkg::FRAME_HEIGHT_RST;
        red_base = ttc_pkg::BASE_RED_RST;
        green_base = ttc_pkg::BASE_GREEN_RST;
        blue_base = ttc_pkg::BASE_BLUE_RST;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_tri(0, 0, 128, 0, 0, 128, 256, 0, 0);
        queue_tri(0, 0, 0, 128, 128, 0, 128, 0, 0);
        queue_tri(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0, 0);
        queue_tri(32767, 32767, -32768, 32767, 32767, -32768, 511, 79, 59);
        queue_tri(16, 16, 16, 16, 16, 16, 257, 0, 0);
        queue_tri(0, 0, 1000, 1000, 2000, 2000, 200, 3, 3);
        queue_tri(100, 100, 100, 100, 100, 100, 1, 255, 255);
        queue_tri(0, 0, 10000, 0, 0, 7000, 256, 79, 59);
        queue_tri(-5, -5, 2000, -5, -5, 2000, 300, 1, 1);
        queue_tri(5000, 5000, 5000, 5000, 5000, 5000, 256, 255, 0);
        queue_tri(8, 8, 120, 40, 40, 120, 255, 0, 0);
        feeding = 1'b1;
        drain();

        write_register(ttc_pkg::REG_FRAME_WIDTH, 12'd4095);
        write_register(ttc_pkg::REG_FRAME_HEIGHT, 12'd4095);
        write_register(ttc_pkg::REG_BASE_RED, 12'd255);
        write_register(ttc_pkg::REG_BASE_GREEN, 12'd0);
        write_register(ttc_pkg::REG_BASE_BLUE, 12'd1);
        queue_tri(-32768, -32768, 32767, -32768, -32768, 32767, 511, 255, 255);
        queue_tri(0, 0, 32767, 0, 0, 32767, 256, 255, 255);
        queue_random(250);
        drain();

        write_register(ttc_pkg::REG_FRAME_WIDTH, 12'd0);
        write_register(ttc_pkg::REG_FRAME_HEIGHT, 12'd1);
        queue_tri(0, 0, 128, 0, 0, 128, 256, 0, 0);
        queue_random(60);
        drain();

        write_register(ttc_pkg::REG_FRAME_WIDTH, 12'd1);
        write_register(ttc_pkg::REG_FRAME_HEIGHT, 12'd0);
        queue_random(40);
        drain();

        write_register(ttc_pkg::REG_FRAME_WIDTH, 12'd2048);
        write_register(ttc_pkg::REG_FRAME_HEIGHT, 12'd2048);
        write_register(ttc_pkg::REG_BASE_RED, 12'd0);
        write_register(ttc_pkg::REG_BASE_GREEN, 12'd255);
        write_register(ttc_pkg::REG_BASE_BLUE, 12'd128);
        queue_random(250);
        drain();

        write_register(ttc_pkg::REG_FRAME_WIDTH, 12'd37);
        write_register(ttc_pkg::REG_FRAME_HEIGHT, 12'd21);
        write_register(ttc_pkg::REG_BASE_RED, 12'hFAA);
        queue_random(150);
        drain();

        write_register(ttc_pkg::REG_FRAME_WIDTH, 12'd640);
        write_register(ttc_pkg::REG_FRAME_HEIGHT, 12'd480);
        write_register(ttc_pkg::REG_BASE_GREEN, 12'($urandom_range(0, 255)));
        write_register(ttc_pkg::REG_BASE_BLUE, 12'($urandom_range(0, 255)));
        queue_random(290);
        drain();

        $display("Checked %0d tiles, %0d with covered pixels, over frame sizes", tiles_checked,
            covered_tiles);
        $display("from empty to beyond the maximum and colors from black to full.");
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/ttc_pkg.sv
rtl/core/ttc_setup.sv
rtl/core/ttc_edge.sv
rtl/core/triangle_tile_coverage_unit.sv
test/triangle_tile_coverage_unit_test.sv
